@@ rtl/fletcher64_block_checksum_unit_macros.svh @@
// Assertion macros shared by the checksum unit modules.
`ifndef FLETCHER64_BLOCK_CHECKSUM_UNIT_MACROS_SVH
`define FLETCHER64_BLOCK_CHECKSUM_UNIT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define F64CS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("f64cs assertion failed");

// Checked on every rising clock edge, reset included.
`define F64CS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("f64cs reset assertion failed");

`endif

@@ rtl/f64cs_pkg.sv @@
// Types, constants and modular arithmetic helpers for the Fletcher-64 checksum unit.
package f64cs_pkg;

  localparam int WORD_W = 32;
  localparam int SUM_W  = 64;
  localparam int POS_W  = 2;

  localparam logic [WORD_W-1:0] MOD32 = 32'hFFFF_FFFF;

  // Everything the finishing stages need once a block has ended.
  typedef struct packed {
    logic [WORD_W-1:0] sum_one;
    logic [WORD_W-1:0] sum_two;
    logic [SUM_W-1:0]  stored;
  } fin_t;

  // Add of two residues in 0..MOD32 with end-around carry; the result stays in 0..MOD32.
  function automatic logic [WORD_W-1:0] eac_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] raw;
    raw = {1'b0, a} + {1'b0, b};
    return raw[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw[WORD_W]};
  endfunction

  // All ones is the same residue as zero.
  function automatic logic [WORD_W-1:0] reduce(input logic [WORD_W-1:0] a);
    return (a == MOD32) ? '0 : a;
  endfunction

endpackage

@@ rtl/f64cs_accum.sv @@
// Input register, header capture and running-sum accumulation of the checksum unit.
`include "fletcher64_block_checksum_unit_macros.svh"

module f64cs_accum #(
  parameter int HEADER_WORDS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [f64cs_pkg::WORD_W-1:0]  in_data_word,
  input  logic                          in_last_word,
  output logic                          fin_valid,
  input  logic                          fin_ready,
  output f64cs_pkg::fin_t               fin_data
);
  import f64cs_pkg::*;

  localparam logic [POS_W-1:0] HDR = POS_W'(HEADER_WORDS);

  logic              v0_r;
  logic [WORD_W-1:0] word_r;
  logic              last_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [WORD_W-1:0] s1_r, s1_nxt;
  logic [WORD_W-1:0] s2_r, s2_nxt;
  logic [SUM_W-1:0]  stored_r, stored_nxt;

  logic              v1_r;
  fin_t              fin_r;

  logic adv1, consume0, in_fire;

  assign adv1     = !v1_r || fin_ready;
  assign consume0 = v0_r && (!last_r || adv1);
  assign in_ready = !v0_r || consume0;
  assign in_fire  = in_valid && in_ready;

  // Header words are captured into the stored checksum; later words feed the sums.
  always_comb begin
    pos_nxt    = pos_r;
    s1_nxt     = s1_r;
    s2_nxt     = s2_r;
    stored_nxt = stored_r;
    if (pos_r < HDR) begin
      if (pos_r == POS_W'(0)) begin
        stored_nxt[WORD_W-1:0] = word_r;
      end else if (pos_r == POS_W'(1)) begin
        stored_nxt[SUM_W-1:WORD_W] = word_r;
      end
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      s1_nxt = eac_add(s1_r, word_r);
      s2_nxt = eac_add(s2_r, s1_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      pos_r    <= '0;
      s1_r     <= '0;
      s2_r     <= '0;
      stored_r <= '0;
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (adv1) begin
        v1_r <= v0_r && last_r;
      end
      if (consume0) begin
        if (last_r) begin
          pos_r    <= '0;
          s1_r     <= '0;
          s2_r     <= '0;
          stored_r <= '0;
        end else begin
          pos_r    <= pos_nxt;
          s1_r     <= s1_nxt;
          s2_r     <= s2_nxt;
          stored_r <= stored_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= in_data_word;
      last_r <= in_last_word;
    end
    if (adv1 && v0_r && last_r) begin
      fin_r.sum_one <= s1_nxt;
      fin_r.sum_two <= s2_nxt;
      fin_r.stored  <= stored_nxt;
    end
  end

  assign fin_valid = v1_r;
  assign fin_data  = fin_r;

  `F64CS_ASSERT(a_pos_bounded, pos_r <= HDR)
  `F64CS_ASSERT(a_block_end_clears,
    (consume0 && last_r) |=> (pos_r == '0 && s1_r == '0 && s2_r == '0 && stored_r == '0))

endmodule

@@ rtl/f64cs_finish.sv @@
// Two-stage finishing path: forms c1, then c2, the checksum and the match flag.
`include "fletcher64_block_checksum_unit_macros.svh"

module f64cs_finish (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fin_valid,
  output logic                         fin_ready,
  input  f64cs_pkg::fin_t              fin_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [f64cs_pkg::SUM_W-1:0]  out_checksum,
  output logic                         out_checksum_ok
);
  import f64cs_pkg::*;

  logic              v2_r;
  logic [WORD_W-1:0] c1_r, c1_nxt;
  logic [WORD_W-1:0] s1_r;
  logic [SUM_W-1:0]  stored_r;

  logic              v3_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              ok_r;
  logic [WORD_W-1:0] c2_nxt;

  logic adv3, adv2;

  assign adv3      = !v3_r || out_ready;
  assign adv2      = !v2_r || adv3;
  assign fin_ready = adv2;

  assign c1_nxt  = MOD32 - reduce(eac_add(fin_data.sum_one, fin_data.sum_two));
  assign c2_nxt  = MOD32 - reduce(eac_add(s1_r, c1_r));
  assign sum_nxt = {c2_nxt, c1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv2) begin
        v2_r <= fin_valid;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && fin_valid) begin
      c1_r     <= c1_nxt;
      s1_r     <= fin_data.sum_one;
      stored_r <= fin_data.stored;
    end
    if (adv3 && v2_r) begin
      sum_r <= sum_nxt;
      ok_r  <= (sum_nxt == stored_r);
    end
  end

  assign out_valid       = v3_r;
  assign out_checksum    = sum_r;
  assign out_checksum_ok = ok_r;

  `F64CS_ASSERT(a_mid_stage_holds, (v2_r && !adv3) |=> v2_r)

endmodule

@@ rtl/fletcher64_block_checksum_unit.sv @@
// Fletcher-64 block checksum unit: top level joining accumulation and finishing.
//
// Usage: a block is streamed in on the input channel (in_valid/in_ready), one
// 32-bit word per transaction, with in_last_word high on the final
// word. The first HEADER_WORDS words carry the stored checksum, low word first,
// and are captured rather than summed. Every later word updates two running sums
// kept modulo 0xFFFFFFFF.
// For each block exactly one result transaction appears on the output channel
// (out_valid/out_ready): the computed checksum c2:c1 and a flag that is high
// when it equals the stored checksum. Words that are not last give no result.
// Throughput is one word per cycle, a last word only while the finishing stages
// have room; the limit is the accumulate step, two chained end-around-carry adds
// feeding the running sums. A result passes the input register, the fin register
// and both finishing stages. A stalled receiver fills them; in_ready then
// drops at a last word. Nothing is lost and results hold steady until taken.
// Reset (rst_n low, synchronous) empties all stages and clears the sums,
// the header position and the captured checksum.
`include "fletcher64_block_checksum_unit_macros.svh"

module fletcher64_block_checksum_unit #(
  parameter int HEADER_WORDS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [f64cs_pkg::WORD_W-1:0]  in_data_word,
  input  logic                          in_last_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [f64cs_pkg::SUM_W-1:0]   out_checksum,
  output logic                          out_checksum_ok
);
  import f64cs_pkg::*;

  logic fin_valid;
  logic fin_ready;
  fin_t fin_data;

  f64cs_accum #(
    .HEADER_WORDS(HEADER_WORDS)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .in_last_word (in_last_word),
    .fin_valid    (fin_valid),
    .fin_ready    (fin_ready),
    .fin_data     (fin_data)
  );

  f64cs_finish u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .fin_valid       (fin_valid),
    .fin_ready       (fin_ready),
    .fin_data        (fin_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_checksum    (out_checksum),
    .out_checksum_ok (out_checksum_ok)
  );

  `F64CS_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!out_valid && in_ready))

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the Fletcher-64 block checksum unit: directed table, then random blocks.
module testbench;
  import f64cs_pkg::*;

  localparam int HDR = 2;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             ok;
  } csum_result_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              typed;
    logic [SUM_W-1:0]  sum;
    logic              ok;
  } dir_row_t;

  localparam logic [SUM_W-1:0] SUM_ONES = {MOD32, MOD32};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [WORD_W-1:0] in_data_word;
  logic              in_last_word;
  logic              out_valid;
  logic              out_ready;
  logic [SUM_W-1:0]  out_checksum;
  logic              out_checksum_ok;

  // Predictor state.
  logic [1:0]        hdr_pos;
  logic [WORD_W-1:0] sum_one;
  logic [WORD_W-1:0] sum_two;
  logic [SUM_W-1:0]  stored_sum;

  csum_result_t expected_results[$];
  int           errors;
  int           stall_left;
  bit           calm;

  dir_row_t directed_rows [24] = '{
    '{32'h0000_0000, 1'b1, 1'b1, SUM_ONES, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, SUM_ONES, 1'b1},
    '{32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, SUM_ONES, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, SUM_ONES, 1'b0},
    '{32'hFFFF_FFFD, 1'b0, 1'b0, '0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, '0, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b1, 64'h0000_0001_FFFF_FFFD, 1'b1},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, '0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, '0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b0, '0, 1'b0},
    '{32'h1234_5678, 1'b0, 1'b0, '0, 1'b0},
    '{32'h9ABC_DEF0, 1'b1, 1'b1, SUM_ONES, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, '0, 1'b0},
    '{32'hFFFF_FFFE, 1'b1, 1'b0, '0, 1'b0}
  };

  fletcher64_block_checksum_unit #(.HEADER_WORDS(HDR)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_checksum    (out_checksum),
    .out_checksum_ok (out_checksum_ok)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, wide[WORD_W]};
  endfunction

  // Folds the two running sums into the c2:c1 checksum.
  function automatic logic [SUM_W-1:0] fold_sums(input logic [WORD_W-1:0] s1,
                                                 input logic [WORD_W-1:0] s2);
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] c1;
    logic [WORD_W-1:0] c2;
    r  = mod_add(s1, s2);
    c1 = MOD32 - ((r == MOD32) ? '0 : r);
    r  = mod_add(s1, c1);
    c2 = MOD32 - ((r == MOD32) ? '0 : r);
    return {c2, c1};
  endfunction

  // Mostly short gaps, now and then a long one; none during calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Data words lean towards the values that stress the end-around carry.
  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return MOD32;
      2: return MOD32 - 1;
      default: return $urandom;
    endcase
  endfunction

  // Advances the predictor by one accepted word and queues any result it causes.
  task automatic predict_word(input logic [WORD_W-1:0] w, input logic last,
                              input logic typed, input csum_result_t typed_res);
    csum_result_t res;
    if (hdr_pos < HDR) begin
      if (hdr_pos == 0) stored_sum[WORD_W-1:0] = w;
      else if (hdr_pos == 1) stored_sum[SUM_W-1:WORD_W] = w;
      hdr_pos = hdr_pos + 2'd1;
    end else begin
      sum_one = mod_add(sum_one, w);
      sum_two = mod_add(sum_two, sum_one);
    end
    if (last) begin
      res.sum = fold_sums(sum_one, sum_two);
      res.ok  = (res.sum == stored_sum);
      expected_results.push_back(typed ? typed_res : res);
      hdr_pos    = '0;
      sum_one    = '0;
      sum_two    = '0;
      stored_sum = '0;
    end
  endtask

  task automatic push_word(input logic [WORD_W-1:0] w, input logic last,
                           input logic typed, input csum_result_t typed_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_word <= w;
    in_last_word <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w, last, typed, typed_res);
  endtask

  // Sends a block with a well-formed header; corrupt flips one bit of the stored checksum.
  task automatic send_block(input int n_data, input bit corrupt, inout int sent);
    logic [WORD_W-1:0] data_words[$];
    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] s2;
    logic [SUM_W-1:0]  cs;
    csum_result_t      none;
    none = '0;
    s1 = '0;
    s2 = '0;
    for (int i = 0; i < n_data; i++) begin
      data_words.push_back(pick_word());
      s1 = mod_add(s1, data_words[i]);
      s2 = mod_add(s2, s1);
    end
    cs = fold_sums(s1, s2);
    if (corrupt) cs = cs ^ ({{(SUM_W-1){1'b0}}, 1'b1} << $urandom_range(0, SUM_W-1));
    push_word(cs[WORD_W-1:0], 1'b0, 1'b0, none);
    push_word(cs[SUM_W-1:WORD_W], 1'b0, 1'b0, none);
    for (int i = 0; i < n_data; i++)
      push_word(data_words[i], i == n_data - 1, 1'b0, none);
    sent += n_data + 2;
  endtask

  // Result side: random back-pressure and comparison against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: checksum %h checksum_ok %b",
                 out_checksum, out_checksum_ok);
          errors++;
        end else begin
          if (out_checksum !== expected_results[0].sum) begin
            $error("checksum: expected %h, got %h", expected_results[0].sum, out_checksum);
            errors++;
          end
          if (out_checksum_ok !== expected_results[0].ok) begin
            $error("checksum_ok: expected %b, got %b", expected_results[0].ok,
                   out_checksum_ok);
            errors++;
          end
          void'(expected_results.pop_front());
        end
      end
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    csum_result_t typed_res;
    csum_result_t none;
    int sent;
    int kind;
    int n;
    int drain;
    errors       = 0;
    calm         = 1'b0;
    none         = '0;
    sent         = 0;
    hdr_pos      = '0;
    sum_one      = '0;
    sum_two      = '0;
    stored_sum   = '0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_word = '0;
    in_last_word = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_res.sum = directed_rows[i].sum;
      typed_res.ok  = directed_rows[i].ok;
      push_word(directed_rows[i].word, directed_rows[i].last, directed_rows[i].typed,
                typed_res);
    end

    while (sent < 1700) begin
      calm = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 62) begin
        n = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 12);
        send_block(n, 1'b0, sent);
      end else if (kind < 75) begin
        send_block($urandom_range(1, 12), 1'b1, sent);
      end else if (kind < 85) begin
        // The block ends while the header is still being captured.
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++)
          push_word(pick_word(), i == n - 1, 1'b0, none);
        sent += n;
      end else begin
        // Noise: random words with the last flag set at random.
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          push_word($urandom, (i == n - 1) || ($urandom_range(0, 4) == 0), 1'b0, none);
        sent += n;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    drain = 0;
    while (expected_results.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d expected transactions never arrived", expected_results.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
